FILE: design/pwg_pkg.sv
// ----------------------------------------------------------------------------
// pwg_pkg
// Shared types, codes and the elaboration-time sine table builder for the
// periodic waveform generator.
// ----------------------------------------------------------------------------
package pwg_pkg;

    typedef logic [1:0]  cfg_index_t;
    typedef logic [15:0] cfg_data_t;
    typedef logic [2:0]  wave_t;

    localparam cfg_index_t REG_WAVE_TYPE = 2'd0;
    localparam cfg_index_t REG_AMPLITUDE = 2'd1;
    localparam cfg_index_t REG_OFFSET    = 2'd2;

    localparam wave_t WAVE_SINE     = 3'd0;
    localparam wave_t WAVE_SQUARE   = 3'd1;
    localparam wave_t WAVE_RAMP     = 3'd2;
    localparam wave_t WAVE_TRIANGLE = 3'd3;
    localparam wave_t WAVE_CONST    = 3'd4;

    localparam int SAMPLE_W = 17;

    // pi/2 in Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Taylor series divisors (2k)(2k+1)
    localparam longint unsigned TAYLOR_DIV [1:12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // sin((i+0.5)*pi/(2N)) rounded half up to Q(unit_sh), evaluated at elaboration
    function automatic longint sine_entry(input int idx, input int table_bits,
                                          input int unit_sh);
        longint unsigned x;
        longint unsigned t;
        longint          s;
        longint          v;
        x = ((longint'(2) * longint'(idx) + longint'(1)) * HALF_PI_Q30) >> (table_bits + 1);
        t = x;
        s = longint'(x);
        for (int k = 1; k <= 12; k++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / TAYLOR_DIV[k];
            if ((k & 1) != 0)
                s = s - longint'(t);
            else
                s = s + longint'(t);
        end
        if (s < 0)
            s = 0;
        v = longint'((longint'(s) * (longint'(1) << unit_sh) + (longint'(1) << 29)) >> 30);
        if (v > (longint'(1) << unit_sh))
            v = longint'(1) << unit_sh;
        return v;
    endfunction

endpackage

FILE: design/periodic_waveform_generator.sv
// ----------------------------------------------------------------------------
// periodic_waveform_generator
// Phase-to-amplitude converter: sine, square, ramp, triangle or constant,
// scaled by a Q15 amplitude and shifted by a Q15 offset.
// ----------------------------------------------------------------------------
// One phase word in, one sample out, one word per clock sustained while
// out_ready is high. The stages are waveform shaping, registered quarter-wave
// sine ROM read, sign selection, the amplitude multiply, then rounding and
// offset into the output register. Each stage stalls only when the one after
// it is full, so a waiting output holds up nothing until the pipe has filled.
// Registers are to be written through the cfg port while the block is idle;
// this binds the user, the block does not enforce it. cfg_ready is always high.
module periodic_waveform_generator #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  pwg_pkg::cfg_index_t  cfg_index,
    input  pwg_pkg::cfg_data_t   cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          phase,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [16:0]   sample
);

    import pwg_pkg::*;

    localparam int US     = SAMPLE_BITS - 1;
    localparam int UW     = SAMPLE_BITS + 1;
    localparam int TB     = SINE_TABLE_BITS;
    localparam int TBL_N  = 1 << TB;
    localparam int PB_IN  = (PHASE_BITS < 32) ? PHASE_BITS : 32;
    localparam int PW     = 16 + UW;

    localparam logic signed [UW-1:0]   ONE       = UW'(1 << US);
    localparam logic signed [UW:0]     ONE_W     = (UW + 1)'(1 << US);
    localparam logic signed [UW:0]     THREE_ONE = (UW + 1)'(3 << US);
    localparam logic signed [PW-1:0]   ROUND     = PW'(1 << (US - 1));

    // configuration
    wave_t              wave_type_reg;
    logic signed [15:0] amplitude_reg;
    logic signed [15:0] offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_type_reg <= WAVE_SINE;
            amplitude_reg <= '0;
            offset_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WAVE_TYPE: wave_type_reg <= cfg_data[2:0];
                REG_AMPLITUDE: amplitude_reg <= cfg_data;
                REG_OFFSET:    offset_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // quarter-wave sine table
    logic [SAMPLE_BITS-1:0] sine_rom [TBL_N];

    for (genvar g = 0; g < TBL_N; g++)
    begin : g_rom
        assign sine_rom[g] = SAMPLE_BITS'(sine_entry(g, TB, US));
    end

    // stage handshake
    logic [5:1] v_reg;
    logic [6:1] en;

    assign en[6] = out_ready;
    for (genvar k = 1; k <= 5; k++)
    begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    assign in_ready  = en[1];
    assign out_valid = v_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[1]) v_reg[1] <= in_valid;
            for (int k = 2; k <= 5; k++)
            begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // stage 1: shape
    logic [47:0]          p_word;
    logic                 half2;
    logic [TB-1:0]        tidx;
    logic [UW-1:0]        f_val;
    logic signed [UW:0]   tri_val;
    logic signed [UW-1:0] u_other;

    always_comb
    begin
        p_word  = 48'(phase[PB_IN-1:0]) << (48 - PHASE_BITS);
        half2   = p_word[47];
        tidx    = p_word[45 -: TB];
        if (p_word[46])
            tidx = ~tidx;
        f_val   = p_word[47 -: UW];
        tri_val = half2 ? (THREE_ONE - signed'({1'b0, f_val}))
                        : (signed'({1'b0, f_val}) - ONE_W);
        case (wave_type_reg)
            WAVE_SQUARE:   u_other = half2 ? -ONE : ONE;
            WAVE_RAMP:     u_other = signed'(UW'(p_word[47 -: US]));
            WAVE_TRIANGLE: u_other = UW'(tri_val);
            default:       u_other = '0;
        endcase
    end

    logic [TB-1:0]          idx1_reg;
    logic                   neg1_reg;
    logic signed [UW-1:0]   uo1_reg;
    logic [SAMPLE_BITS-1:0] rom2_reg;
    logic                   neg2_reg;
    logic signed [UW-1:0]   uo2_reg;
    logic signed [UW-1:0]   u3_reg;
    logic signed [PW-1:0]   prod4_reg;
    logic signed [16:0]     sample5_reg;

    logic signed [UW-1:0]   u3_next;
    logic signed [PW-1:0]   rnd;
    logic signed [16:0]     q_val;
    logic signed [16:0]     sample5_next;

    always_comb
    begin
        if (wave_type_reg == WAVE_SINE)
            u3_next = neg2_reg ? -signed'({1'b0, rom2_reg}) : signed'({1'b0, rom2_reg});
        else
            u3_next = uo2_reg;

        rnd   = prod4_reg + ROUND;
        q_val = 17'(rnd >>> US);
        case (wave_type_reg)
            WAVE_SINE, WAVE_SQUARE, WAVE_RAMP, WAVE_TRIANGLE:
                sample5_next = q_val + 17'(offset_reg);
            WAVE_CONST:
                sample5_next = 17'(offset_reg);
            default:
                sample5_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            idx1_reg <= tidx;
            neg1_reg <= p_word[47];
            uo1_reg  <= u_other;
        end
        if (en[2])
        begin
            rom2_reg <= sine_rom[idx1_reg];
            neg2_reg <= neg1_reg;
            uo2_reg  <= uo1_reg;
        end
        if (en[3])
            u3_reg <= u3_next;
        if (en[4])
            prod4_reg <= PW'(amplitude_reg) * PW'(u3_reg);
        if (en[5])
            sample5_reg <= sample5_next;
    end

    assign sample = sample5_reg;

`ifndef ASSERT_OFF
    // input stalls only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&v_reg) && !out_ready)
        else $error("input stalled with a free stage");

    // unit waveform never leaves [-1.0, 1.0]
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[3] |-> (u3_reg <= ONE) && (u3_reg >= -ONE))
        else $error("unit waveform out of range");
`endif

endmodule

FILE: dv/tb_periodic_waveform_generator.sv
// ----------------------------------------------------------------------------
// tb_periodic_waveform_generator
// Self-checking bench for the phase-to-amplitude converter. Register settings
// are loaded while the pipe is empty. A short directed set then a long random
// run of phase words are pushed through with random gaps and output stalls.
// Each sample is checked against an in-bench prediction of the waveform,
// amplitude scaling, rounding and offset.
// ----------------------------------------------------------------------------
module tb_periodic_waveform_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import pwg_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed {
        cfg_index_t idx;
        cfg_data_t  data;
    } reg_write_t;

    localparam cfg_index_t REG_SPARE   = 2'd3;
    localparam int         LUT_BITS    = 10;
    localparam int         LUT_SIZE    = 1 << LUT_BITS;
    localparam u64_t       QUARTER_Q30 = 64'd1686629713;
    localparam longint     UNIT_ONE    = 32768;
    localparam int         RAND_SETS   = 10;
    localparam int         SET_WORDS   = 125;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = '0;
    cfg_data_t             cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [31:0]           phase     = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [16:0]    sample;

    // shadow copy of the block's registers and its quarter-wave table
    wave_t                 wave_sel  = WAVE_SINE;
    logic signed [15:0]    amp_q15   = '0;
    logic signed [15:0]    offs_q15  = '0;
    longint                sine_lut [LUT_SIZE];

    reg_write_t            cfg_writes_q [$];
    logic [31:0]           phase_words_q [$];
    logic signed [16:0]    expected_samples_q [$];

    bit                    in_gaps_on    = 1'b0;
    bit                    out_stalls_on = 1'b0;
    int                    in_gap        = 0;
    int                    out_stall     = 0;
    int                    errors        = 0;
    int                    n_checked     = 0;
    int                    n_settings    = 0;
    int                    wave_hits [8];
    logic signed [16:0]    want;

    periodic_waveform_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .phase     (phase),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample)
    );

    always #5 clk = ~clk;

    // sin((i+0.5)*pi/(2N)) by Taylor series in Q30, rounded half up to Q15
    function automatic longint quarter_sine_q15(input int i);
        u64_t   x;
        u64_t   t;
        longint s;
        longint v;
        x = (u64_t'(2 * i + 1) * QUARTER_Q30) >> (LUT_BITS + 1);
        t = x;
        s = longint'(x);
        for (int k = 1; k <= 12; k++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / (u64_t'(2 * k) * u64_t'(2 * k + 1));
            if (k % 2 == 1)
                s = s - longint'(t);
            else
                s = s + longint'(t);
        end
        if (s < 0)
            s = 0;
        v = longint'((u64_t'(s) * u64_t'(UNIT_ONE) + (u64_t'(1) << 29)) >> 30);
        if (v > UNIT_ONE)
            v = UNIT_ONE;
        return v;
    endfunction

    function automatic logic signed [16:0] waveform_sample(input logic [31:0] ph);
        logic [1:0]         quad;
        logic [9:0]         idx;
        longint             u;
        longint             f;
        longint             smp;
        logic signed [16:0] r;
        u = 0;
        case (wave_sel)
            WAVE_SINE:
            begin
                quad = ph[31:30];
                idx  = ph[29:20];
                if (quad[0])
                    idx = ~idx;
                u = sine_lut[idx];
                if (quad[1])
                    u = -u;
            end
            WAVE_SQUARE:   u = ph[31] ? -UNIT_ONE : UNIT_ONE;
            WAVE_RAMP:     u = longint'(ph[31:17]);
            WAVE_TRIANGLE:
            begin
                f = longint'(ph[31:15]);
                u = ph[31] ? (3 * UNIT_ONE - f) : (f - UNIT_ONE);
            end
            default:       u = 0;
        endcase
        if (wave_sel <= WAVE_TRIANGLE)
            smp = ((longint'(amp_q15) * u + UNIT_ONE / 2) >>> 15) + longint'(offs_q15);
        else if (wave_sel == WAVE_CONST)
            smp = longint'(offs_q15);
        else
            smp = 0;
        r = smp[16:0];
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] random_phase();
        logic [31:0] base;
        if ($urandom_range(0, 9) < 2)
        begin
            // near a quadrant boundary
            base = 32'($urandom_range(0, 3)) << 30;
            return base + 32'($urandom_range(0, 7)) - 32'd4;
        end
        return $urandom;
    endfunction

    function automatic cfg_data_t random_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h8000;
        if (r == 1)
            return 16'h7FFF;
        if (r == 2)
            return 16'h0000;
        return cfg_data_t'($urandom);
    endfunction

    function automatic cfg_data_t random_wave_word();
        int         c;
        logic [12:0] junk;
        c = $urandom_range(0, 11);
        if (c > 7)
            c = c - 8;
        junk = 13'($urandom);
        return {junk, 3'(c)};
    endfunction

    // register write channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
        end
        else if (!cfg_valid || cfg_ready)
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_WAVE_TYPE: wave_sel = cfg_data[2:0];
                    REG_AMPLITUDE: amp_q15  = cfg_data;
                    REG_OFFSET:    offs_q15 = cfg_data;
                    default: ;
                endcase
            end
            if (cfg_writes_q.size() != 0)
            begin
                cfg_index <= cfg_writes_q[0].idx;
                cfg_data  <= cfg_writes_q[0].data;
                cfg_valid <= 1'b1;
                void'(cfg_writes_q.pop_front());
            end
            else
                cfg_valid <= 1'b0;
        end
    end

    // phase word driver, prediction on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_samples_q.push_back(waveform_sample(phase));
                wave_hits[wave_sel] = wave_hits[wave_sel] + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (phase_words_q.size() != 0)
                begin
                    phase    <= phase_words_q.pop_front();
                    in_valid <= 1'b1;
                    if (in_gaps_on)
                        in_gap = draw_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // sample monitor and output back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_samples_q.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: sample mismatch: expected none, got %0d", $time, sample);
                end
                else
                begin
                    want = expected_samples_q.pop_front();
                    n_checked = n_checked + 1;
                    if (sample !== want)
                    begin
                        errors = errors + 1;
                        $display("%0t: sample mismatch: expected %0d, got %0d",
                                 $time, want, sample);
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall = out_stall - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_stalls_on && $urandom_range(0, 2) == 0)
                    out_stall = draw_gap();
            end
        end
    end

    task automatic program_regs(input cfg_data_t wave_word, input cfg_data_t amp,
                                input cfg_data_t offs, input bit spare);
        reg_write_t w;
        @(negedge clk);
        in_gaps_on    = (n_settings % 4) != 0;
        out_stalls_on = (n_settings % 3) != 1;
        n_settings    = n_settings + 1;
        w = '{idx: REG_WAVE_TYPE, data: wave_word};
        cfg_writes_q.push_back(w);
        w = '{idx: REG_AMPLITUDE, data: amp};
        cfg_writes_q.push_back(w);
        w = '{idx: REG_OFFSET, data: offs};
        cfg_writes_q.push_back(w);
        if (spare)
        begin
            // unmapped index, must leave every register alone
            w = '{idx: REG_SPARE, data: cfg_data_t'($urandom)};
            cfg_writes_q.push_back(w);
        end
        while (cfg_writes_q.size() != 0 || cfg_valid)
            @(negedge clk);
    endtask

    task automatic drain();
        while (phase_words_q.size() != 0 || in_valid || expected_samples_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < LUT_SIZE; i++)
            sine_lut[i] = quarter_sine_q15(i);
        for (int i = 0; i < 8; i++)
            wave_hits[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: quadrant edges and full-scale settings
        program_regs(cfg_data_t'(WAVE_SINE), 16'h7FFF, 16'h0000, 1'b0);
        phase_words_q = '{32'h0000_0000, 32'h3FFF_FFFF, 32'h4000_0000,
                          32'h8000_0000, 32'hC000_0000, 32'hFFFF_FFFF};
        drain();
        program_regs(cfg_data_t'(WAVE_SINE), 16'h8000, 16'h8000, 1'b0);
        phase_words_q = '{32'h3FFF_FFFF, 32'h4000_0000};
        drain();
        program_regs({13'h1FFF, WAVE_SQUARE}, 16'h8000, 16'h7FFF, 1'b1);
        phase_words_q = '{32'h7FFF_FFFF, 32'h8000_0000};
        drain();
        program_regs(cfg_data_t'(WAVE_RAMP), 16'h7FFF, 16'h8000, 1'b0);
        phase_words_q = '{32'h0000_0000, 32'hFFFF_FFFF};
        drain();
        program_regs(cfg_data_t'(WAVE_TRIANGLE), 16'h8000, 16'h8000, 1'b0);
        phase_words_q = '{32'h0000_0000, 32'h3FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'hFFFF_FFFF};
        drain();
        program_regs({13'h1FFF, WAVE_CONST}, cfg_data_t'($urandom), 16'h7FFF, 1'b1);
        phase_words_q = '{32'h1234_5678};
        drain();
        for (int c = WAVE_CONST + 1; c < 8; c++)
        begin
            program_regs(cfg_data_t'(c), 16'h7FFF, 16'h7FFF, 1'b0);
            phase_words_q.push_back($urandom);
            drain();
        end

        // random settings, each with a batch of phase words
        for (int k = 0; k < RAND_SETS; k++)
        begin
            program_regs(random_wave_word(), random_level(), random_level(),
                         $urandom_range(0, 3) == 0);
            for (int n = 0; n < SET_WORDS; n++)
                phase_words_q.push_back(random_phase());
            drain();
        end

        repeat (10) @(posedge clk);
        $display("checked %0d samples across %0d register settings", n_checked, n_settings);
        $display("samples per wave code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 wave_hits[0], wave_hits[1], wave_hits[2], wave_hits[3],
                 wave_hits[4], wave_hits[5], wave_hits[6], wave_hits[7]);
        if (errors == 0)
            $display("periodic_waveform_generator test passed");
        else
            $display("periodic_waveform_generator test failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout: %0d samples still outstanding", expected_samples_q.size());
        $display("periodic_waveform_generator test failed");
        $finish;
    end

endmodule
